### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable priority queue
// Operation and status codes, the entry type and the cell control word.
// ---------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int FUNC_W   = 2;
	localparam int PAYLOAD_W = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// operation codes (code 3 is a no-op)
	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_SERVE  = 2'd1;
	localparam logic [FUNC_W-1:0] OP_PEEK   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [PAYLOAD_W-1:0]     payload;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// what every cell of the chain does this cycle
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INSERT,
		SH_SERVE
	} shift_op_t;

	typedef struct packed {
		shift_op_t op;
		entry_t    new_entry;
	} cell_ctrl_t;

endpackage

### rtl/spq_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_req_if / spq_rsp_if: valid-ready channels of the priority queue
// Request carries one operation, response carries its result.
// ---------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [PAYLOAD_W-1:0]     payload;
	logic signed [PRIO_W-1:0] priority_req;

	modport source (output valid, func, payload, priority_req, input ready);
	modport sink   (input valid, func, payload, priority_req, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [PAYLOAD_W-1:0]     head_payload;
	logic signed [PRIO_W-1:0] head_priority;
	logic [COUNT_W-1:0]       entry_count;

	modport source (output valid, status, head_payload, head_priority, entry_count,
		input ready);
	modport sink   (input valid, status, head_payload, head_priority, entry_count,
		output ready);
endinterface

### rtl/stable_priority_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue, FIFO among equals
// A chain of CAPACITY cells keeps entries sorted with the head in cell 0.
// ---------------------------------------------------------------------------
// A result is registered and valid in the cycle after its request transaction.
// Throughput: one operation per cycle while the response is taken; every cell
//   compares and shifts in the same cycle, so the chain's update sets the rate.
// A stalled response holds the request side through the output register.
// Reset clears the entry count and the response valid; cell contents stay
//   undefined and are never reported before they are written.
module stable_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	spq_req_if.sink         req,
	spq_rsp_if.source       rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic                      rsp_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [STATUS_W-1:0]       status_d;
	entry_t                    head_q;
	entry_t                    head_d;
	logic [COUNT_W-1:0]        entry_count_q;
	logic                      accept;
	logic                      full;
	logic                      empty;
	cell_ctrl_t                ctrl;

	entry_t                    cell_entry [CAPACITY];
	logic   [CAPACITY-1:0]     cell_keep;

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	// decode the transaction into a chain command
	always_comb begin
		ctrl.new_entry.payload = req.payload;
		ctrl.new_entry.prio    = req.priority_req;
		ctrl.op  = SH_HOLD;
		count_d  = count_q;
		status_d = ST_OK;
		head_d   = '0;
		if (accept) begin
			unique case (req.func)
				OP_INSERT: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ctrl.op = SH_INSERT;
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_SERVE, OP_PEEK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						head_d = cell_entry[0];
						if (req.func == OP_SERVE) begin
							ctrl.op = SH_SERVE;
							count_d = count_q - CNT_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// build the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;
		logic   occ;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_e = ctrl.new_entry;
			assign left_k = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// advance count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// hold the response payload until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			head_q        <= head_d;
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.head_payload  = head_q.payload;
	assign rsp.head_priority = head_q.prio;
	assign rsp.entry_count   = entry_count_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.func == OP_INSERT && full |=> rsp_valid_q && status_q == ST_FULL)
		else $error("insert into full queue not flagged");

	a_serve_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.func == OP_SERVE && !empty |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("serve did not remove an entry");

	a_empty_peek: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.func == OP_PEEK && empty |=> status_q == ST_EMPTY && head_q == '0)
		else $error("peek of empty queue misreported");

endmodule

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted register chain
// Holds one entry, compares it against an incoming insert and shifts
// toward the tail on insert or toward the head on serve.
// ---------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occupied,
	input  entry_t     left_entry,
	input  logic       left_keep,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       keep
);

	entry_t entry_q;
	entry_t entry_d;

	// stay in place when held entry ranks at or above the new one
	assign keep = occupied && (entry_q.prio >= ctrl.new_entry.prio);

	// pick next contents
	always_comb begin
		case (ctrl.op)
			SH_INSERT: begin
				if (keep)
					entry_d = entry_q;
				else if (left_keep)
					entry_d = ctrl.new_entry;
				else
					entry_d = left_entry;
			end
			SH_SERVE: entry_d = right_entry;
			default:  entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

### tb/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// Drives insert, serve, peek and no-op transactions through the request
// channel and keeps a sorted shadow list of the entries to predict every
// response: head entry, status and entry count. Directed corner cases come
// first, then biased random traffic that swings the queue between empty and
// full, under phases of sender idling and receiver back-pressure.
// ---------------------------------------------------------------------------
module stable_priority_queue_tb import spq_pkg::*; ();

	localparam int QUEUE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 450;
	localparam logic [FUNC_W-1:0] OP_NOP = 2'd3;

	// idle phases of the run
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [PAYLOAD_W-1:0]     head_payload;
		logic signed [PRIO_W-1:0] head_priority;
		logic [COUNT_W-1:0]       entry_count;
	} queue_result_t;

	// -----------------------------------------------------------------------
	// shadow of the sorted entry list and the queue of expected responses
	// -----------------------------------------------------------------------
	class spq_scoreboard;
		entry_t        slots[QUEUE_DEPTH];
		int unsigned   held;
		queue_result_t pending_results[$];
		int            errors;
		int            n_insert, n_dropped, n_serve, n_peek, n_empty, n_nop;

		function new();
			held = 0;
			errors = 0;
			n_insert = 0;
			n_dropped = 0;
			n_serve = 0;
			n_peek = 0;
			n_empty = 0;
			n_nop = 0;
		endfunction

		// update the shadow list for one accepted request and queue its result
		function void note_request(logic [FUNC_W-1:0] func, logic [PAYLOAD_W-1:0] payload,
			logic signed [PRIO_W-1:0] prio);
			queue_result_t res;
			int unsigned   pos;
			res = '0;
			res.status = ST_OK;
			if (func == OP_INSERT) begin
				n_insert++;
				if (held >= QUEUE_DEPTH) begin
					res.status = ST_FULL;
					n_dropped++;
				end else begin
					// go behind every entry of greater or equal priority
					pos = 0;
					while (pos < held && slots[pos].prio >= prio)
						pos++;
					for (int i = held; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos].payload = payload;
					slots[pos].prio = prio;
					held++;
				end
			end else if (func == OP_SERVE || func == OP_PEEK) begin
				if (func == OP_SERVE)
					n_serve++;
				else
					n_peek++;
				if (held == 0) begin
					res.status = ST_EMPTY;
					n_empty++;
				end else begin
					res.head_payload = slots[0].payload;
					res.head_priority = slots[0].prio;
					if (func == OP_SERVE) begin
						for (int i = 0; i + 1 < held; i++)
							slots[i] = slots[i+1];
						held--;
					end
				end
			end else begin
				n_nop++;
			end
			res.entry_count = held[COUNT_W-1:0];
			pending_results.push_back(res);
		endfunction

		// compare one accepted response with the oldest expectation
		function void check_response(queue_result_t got);
			queue_result_t want;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: status %0d payload %h",
					got.status, got.head_payload);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.head_payload !== want.head_payload) begin
				$error("head_payload: expected %h, actual %h", want.head_payload,
					got.head_payload);
				errors++;
			end
			if (got.head_priority !== want.head_priority) begin
				$error("head_priority: expected %0d, actual %0d", want.head_priority,
					got.head_priority);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count,
					got.entry_count);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	idle_mode_t idle_mode;
	spq_scoreboard sb;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	stable_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// end a hung run
	initial begin
		#2ms;
		$display("timeout waiting for the queue to drain");
		$display("TEST FAILED");
		$finish;
	end

	// stall the response channel according to the phase
	always @(negedge clk) begin
		if ((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 68) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 27))
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= 1'b1;
	end

	// record every transaction on both channels
	always @(posedge clk) begin
		queue_result_t got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.func, req_ch.payload, req_ch.priority_req);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.status = rsp_ch.status;
				got.head_payload = rsp_ch.head_payload;
				got.head_priority = rsp_ch.head_priority;
				got.entry_count = rsp_ch.entry_count;
				sb.check_response(got);
			end
		end
	end

	// present one request at a falling edge and hold it until accepted
	task automatic send_op(input logic [FUNC_W-1:0] func, input logic [PAYLOAD_W-1:0] payload,
		input logic signed [PRIO_W-1:0] prio);
		while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 68) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 27)) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= func;
		req_ch.payload <= payload;
		req_ch.priority_req <= prio;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// mostly a narrow band to force ties, sometimes the extremes or anything
	function automatic logic signed [PRIO_W-1:0] pick_prio();
		logic signed [PRIO_W-1:0] p;
		case ($urandom_range(9))
			0: p = 16'sh7fff;
			1: p = 16'sh8000;
			2, 3, 4: p = 16'($urandom_range(4)) - 16'sd2;
			5, 6: p = 16'($urandom_range(2));
			default: p = 16'($urandom);
		endcase
		return p;
	endfunction

	function automatic logic [PAYLOAD_W-1:0] pick_payload();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [FUNC_W-1:0] func;
		logic signed [PRIO_W-1:0] prio;
		int roll;
		bit fill_bias;

		sb = new();
		idle_mode = IDLE_NONE;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = OP_INSERT;
		req_ch.payload = '0;
		req_ch.priority_req = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue: serve, peek with all ones on the fields, then a no-op
		send_op(OP_SERVE, '0, '0);
		send_op(OP_PEEK, '1, '1);
		send_op(OP_NOP, '1, 16'sh8000);

		// fill to capacity with extremes and ties
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			case (i % 4)
				0: prio = 16'sh7fff;
				1: prio = 16'sh8000;
				2: prio = 16'sd0;
				default: prio = 16'(i % 3) - 16'sd1;
			endcase
			send_op(OP_INSERT, (i == 0) ? '0 : (i == QUEUE_DEPTH - 1) ? '1 :
				32'h5a00_0000 + i, prio);
		end

		// full queue: dropped insert, peek, no-op, then a few serves
		send_op(OP_INSERT, 32'hdead_beef, 16'sh7fff);
		send_op(OP_PEEK, '0, '0);
		send_op(OP_NOP, '0, '0);
		repeat (3) send_op(OP_SERVE, '0, '0);

		// random traffic in four idle phases, biased to swing empty and full
		fill_bias = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n / (RANDOM_ITEMS / 4))
				0: idle_mode = IDLE_SENDER;
				1: idle_mode = IDLE_RECEIVER;
				2: idle_mode = IDLE_BOTH;
				default: idle_mode = IDLE_NONE;
			endcase
			if (n % 30 == 0)
				fill_bias = ~fill_bias;
			roll = $urandom_range(99);
			if (roll < 3)
				func = OP_NOP;
			else if (roll < 18)
				func = OP_PEEK;
			else if (roll < (fill_bias ? 78 : 38))
				func = OP_INSERT;
			else
				func = OP_SERVE;
			send_op(func, pick_payload(), pick_prio());
		end
		req_ch.valid <= 1'b0;
		idle_mode = IDLE_NONE;

		// drain, then wait out any stray response
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d inserts (%0d dropped on full), %0d serves, %0d peeks,",
			sb.n_insert, sb.n_dropped, sb.n_serve, sb.n_peek);
		$display("%0d empty replies and %0d no-ops, under four idle phases",
			sb.n_empty, sb.n_nop);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
